>>> hdl/lrukv_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies; imported by lrukv_rank, the top level and the bench.
package lrukv_pkg;

  // Field widths fixed by the item format
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CAP_W  = 5;

  // Default depth and capacity register reset value
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

  // Operation codes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Value returned by a get that misses
  localparam logic [DATA_W-1:0] MISS_VALUE = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_RESP
  } state_e;

  // Recency update request from the sequencer
  typedef struct packed {
    logic touch;   // move an existing entry to most recent
    logic insert;  // age all others and install a new most recent entry
  } rank_ctrl_t;

endpackage

>>> hdl/lrukv_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; used for the key and value stores.
module lrukv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lrukv_rank.sv
// Valid bits and recency ranks for every cache entry, updated in parallel.
// Depends on lrukv_pkg for the update request type.
module lrukv_rank #(
  parameter int unsigned MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lrukv_pkg::rank_ctrl_t          ctrl_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0] slot_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0] ref_rank_i,
  input  logic [$clog2(MAX_ENTRIES)-1:0] rd_idx_i,
  output logic [MAX_ENTRIES-1:0]         valid_o,
  output logic                           rd_valid_o,
  output logic [$clog2(MAX_ENTRIES)-1:0] rd_rank_o
);
  import lrukv_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES);

  logic [MAX_ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0]          rank_q [MAX_ENTRIES];
  logic [IW-1:0]          rank_d [MAX_ENTRIES];

  // Age entries and install the chosen slot as most recent
  always_comb begin
    valid_d = valid_q;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (ctrl_i.touch) begin
        if (IW'(i) == slot_i) begin
          rank_d[i] = '0;
        end else if (valid_q[i] && (rank_q[i] < ref_rank_i)) begin
          rank_d[i] = rank_q[i] + IW'(1);
        end
      end else if (ctrl_i.insert) begin
        if (IW'(i) == slot_i) begin
          rank_d[i]  = '0;
          valid_d[i] = 1'b1;
        end else if (valid_q[i]) begin
          rank_d[i] = rank_q[i] + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  assign valid_o    = valid_q;
  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];

  // Touch and insert never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_i.touch && ctrl_i.insert))
    else $error("lrukv_rank: touch and insert together");

  // A touched entry must already be valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.touch |-> valid_q[slot_i])
    else $error("lrukv_rank: touch of an invalid entry");

  // An installed entry reads back as valid and most recent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.insert |=> (valid_q[$past(slot_i)] && rank_q[$past(slot_i)] == '0))
    else $error("lrukv_rank: inserted entry not most recent");

endmodule

>>> hdl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: sequencer, key/value stores, outputs.
// Depends on lrukv_pkg, lrukv_ram and lrukv_rank.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | operation_i, lookup_key_i, write_value_i
//  out     | output    | out_valid_o/out_ready_i| found_o, read_value_o, evicted_o,
//          |           |                        | evicted_key_o
//  cfg     | input     | cfg_we_i (no wait)     | cfg_wdata_i (capacity_in_use)
//
// An item is accepted in idle, then the single key comparator walks the key RAM
// one entry a cycle, then come one value RAM read and the commit.
// The next item is accepted in the cycle after the commit.
// Reset empties the cache at once (valid bits in flops) and sets capacity to 16.
// A result held by a stalled output does not block acceptance; only the commit of
// the following item waits for the output register to free.
module lru_key_value_cache_top #(
  parameter int unsigned MAX_ENTRIES = lrukv_pkg::MAX_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                operation_i,
  input  logic signed [lrukv_pkg::DATA_W-1:0] lookup_key_i,
  input  logic signed [lrukv_pkg::DATA_W-1:0] write_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                found_o,
  output logic signed [lrukv_pkg::DATA_W-1:0] read_value_o,
  output logic                                evicted_o,
  output logic signed [lrukv_pkg::DATA_W-1:0] evicted_key_o,
  input  logic                                cfg_we_i,
  input  logic [lrukv_pkg::CAP_W-1:0]         cfg_wdata_i
);
  import lrukv_pkg::*;

  localparam int unsigned IW   = $clog2(MAX_ENTRIES);
  localparam int unsigned CW   = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMPW = (CW > CAP_W) ? CW : CAP_W;

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [CAP_W-1:0]  cap_q;

  logic              op_q;
  logic [DATA_W-1:0] key_q, val_q;

  logic              hit_q, hit_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  logic [IW-1:0]     hit_rank_q, hit_rank_d;
  logic              free_seen_q, free_seen_d;
  logic [IW-1:0]     free_idx_q, free_idx_d;
  logic [IW-1:0]     lru_idx_q, lru_idx_d;
  logic [DATA_W-1:0] lru_key_q, lru_key_d;

  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [DATA_W-1:0] rdval_q, rdval_d;
  logic              evicted_q, evicted_d;
  logic [DATA_W-1:0] evkey_q, evkey_d;

  logic              accept;
  logic              commit;
  logic              full;
  logic              evict;
  logic [CAP_W-1:0]  cap_eff;
  logic [IW-1:0]     cmp_idx;
  logic [IW-1:0]     ins_slot;
  logic [IW-1:0]     wr_slot;

  logic              key_we, val_we;
  logic [IW-1:0]     key_addr, val_addr;
  logic [DATA_W-1:0] key_rdata, val_rdata;

  rank_ctrl_t             rank_ctrl;
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic                   rd_valid;
  logic [IW-1:0]          rd_rank;

  // Capacity clamp: zero acts as one, the depth caps the top
  assign cap_eff = (cap_q == '0) ? CAP_W'(1) : cap_q;
  assign full    = (CMPW'(occ_q) >= CMPW'(cap_eff)) || (occ_q == CW'(MAX_ENTRIES));
  assign evict   = (op_q == OP_PUT) && !hit_q && full;

  assign accept   = in_valid_i && in_ready_o;
  assign cmp_idx  = IW'(cnt_q - CW'(1));
  assign ins_slot = evict ? lru_idx_q : free_idx_q;
  assign wr_slot  = hit_q ? hit_idx_q : ins_slot;

  // Key store: scanned by the counter, written on insert
  assign key_we   = commit && (op_q == OP_PUT) && !hit_q;
  assign key_addr = key_we ? ins_slot : cnt_q[IW-1:0];

  // Value store: read at the hit slot, written by every put
  assign val_we   = commit && (op_q == OP_PUT);
  assign val_addr = val_we ? wr_slot : hit_idx_q;

  lrukv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (key_addr),
    .wdata_i (key_q),
    .rdata_o (key_rdata)
  );

  lrukv_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_ENTRIES)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .addr_i  (val_addr),
    .wdata_i (val_q),
    .rdata_o (val_rdata)
  );

  // Recency tracking
  assign rank_ctrl.touch  = commit && hit_q;
  assign rank_ctrl.insert = commit && (op_q == OP_PUT) && !hit_q;

  lrukv_rank #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rank_ctrl),
    .slot_i     (wr_slot),
    .ref_rank_i (hit_rank_q),
    .rd_idx_i   (cmp_idx),
    .valid_o    (valid_vec),
    .rd_valid_o (rd_valid),
    .rd_rank_o  (rd_rank)
  );

  // Sequencer: next state, scan bookkeeping and result
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    occ_d       = occ_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_rank_d  = hit_rank_q;
    free_seen_d = free_seen_q;
    free_idx_d  = free_idx_q;
    lru_idx_d   = lru_idx_q;
    lru_key_d   = lru_key_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    rdval_d     = rdval_q;
    evicted_d   = evicted_q;
    evkey_d     = evkey_q;
    in_ready_o  = 1'b0;
    commit      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cnt_d       = '0;
          hit_d       = 1'b0;
          free_seen_d = 1'b0;
          state_d     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        // Compare the entry whose key arrived this cycle
        if (cnt_q != '0) begin
          if (rd_valid && (key_rdata == key_q) && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = cmp_idx;
            hit_rank_d = rd_rank;
          end
          if (!rd_valid && !free_seen_q) begin
            free_seen_d = 1'b1;
            free_idx_d  = cmp_idx;
          end
          if (rd_valid && (rd_rank == IW'(occ_q - CW'(1)))) begin
            lru_idx_d = cmp_idx;
            lru_key_d = key_rdata;
          end
        end
        if (cnt_q == CW'(MAX_ENTRIES)) begin
          state_d = ST_FETCH;
        end
      end

      ST_FETCH: begin
        state_d = ST_RESP;
      end

      ST_RESP: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          commit      = 1'b1;
          out_valid_d = 1'b1;
          found_d     = hit_q;
          evicted_d   = evict;
          evkey_d     = evict ? lru_key_q : '0;
          if (op_q == OP_GET) begin
            rdval_d = hit_q ? val_rdata : MISS_VALUE;
          end else begin
            rdval_d = '0;
            if (!hit_q && !evict) begin
              occ_d = occ_q + CW'(1);
            end
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      occ_q       <= '0;
      cap_q       <= CAPACITY_RESET;
      hit_q       <= 1'b0;
      free_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      occ_q       <= occ_d;
      hit_q       <= hit_d;
      free_seen_q <= free_seen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      key_q <= lookup_key_i;
      val_q <= write_value_i;
    end
    hit_idx_q  <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    free_idx_q <= free_idx_d;
    lru_idx_q  <= lru_idx_d;
    lru_key_q  <= lru_key_d;
    found_q    <= found_d;
    rdval_q    <= rdval_d;
    evicted_q  <= evicted_d;
    evkey_q    <= evkey_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign read_value_o  = rdval_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evkey_q;

  // Occupancy counts exactly the valid entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == int'(occ_q))
    else $error("occupancy does not match valid entries");

  // An accepted item starts a fresh scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN && cnt_q == '0 && !hit_q))
    else $error("scan did not start after accept");

  // Eviction only from a non-empty cache and never alongside a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && evict) |-> (occ_q != '0 && !hit_q))
    else $error("eviction from empty cache or on a hit");

  // A held result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(rdval_q) && $stable(evkey_q)))
    else $error("stalled result changed");

endmodule

>>> tb/sv/tb_top.sv
// Self-checking bench for lru_key_value_cache_top: directed and random get/put items
// checked against an in-bench LRU predictor, with idling, stalls and capacity changes.
// Depends on lrukv_pkg and the cache RTL only.
module tb_top;
  import lrukv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 48;
  localparam int SETTLE_CYCLES = 2 * (MAX_ENTRIES_DEF + 4);

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
  } cache_req_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              evicted;
    logic [DATA_W-1:0] evicted_key;
  } cache_resp_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              operation_i = OP_GET;
  logic [DATA_W-1:0] lookup_key_i = '0;
  logic [DATA_W-1:0] write_value_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              found_o;
  logic [DATA_W-1:0] read_value_o;
  logic              evicted_o;
  logic [DATA_W-1:0] evicted_key_o;
  logic              cfg_we_i = 1'b0;
  logic [CAP_W-1:0]  cfg_wdata_i = '0;

  // Bench state
  cache_req_t  req_queue[$];
  cache_resp_t resp_queue[$];
  cache_req_t  next_req;
  cache_resp_t due_resp;
  logic        in_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          accepted_count = 0;
  int          returned_count = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  logic [DATA_W-1:0] key_pool[POOL_SIZE];

  // Predictor state: key/value slots, valid bits, recency ranks (0 = newest)
  logic [DATA_W-1:0] slot_key[MAX_ENTRIES_DEF];
  logic [DATA_W-1:0] slot_value[MAX_ENTRIES_DEF];
  logic              slot_live[MAX_ENTRIES_DEF] = '{default: 1'b0};
  int                slot_age[MAX_ENTRIES_DEF] = '{default: 0};
  int                live_count = 0;
  logic [CAP_W-1:0]  capacity_reg = CAPACITY_RESET;

  lru_key_value_cache_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .lookup_key_i (lookup_key_i),
    .write_value_i(write_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .found_o      (found_o),
    .read_value_o (read_value_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  always begin
    #4;
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
  end

  // Move slot s to most recent, ageing every live entry that was newer
  function automatic void promote_slot(input int s);
    int i;
    for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
      if (slot_live[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
    end
    slot_age[s] = 0;
  endfunction

  // Apply one get or put to the predicted cache and return the expected result
  function automatic cache_resp_t cache_access(input cache_req_t req);
    cache_resp_t resp;
    int hit;
    int slot;
    int room;
    int i;
    resp = '0;
    hit  = -1;
    slot = -1;
    for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
      if (hit < 0 && slot_live[i] && slot_key[i] == req.key) hit = i;
    end
    if (req.op == OP_GET) begin
      if (hit >= 0) begin
        resp.found      = 1'b1;
        resp.read_value = slot_value[hit];
        promote_slot(hit);
      end else begin
        resp.read_value = MISS_VALUE;
      end
    end else if (hit >= 0) begin
      resp.found      = 1'b1;
      slot_value[hit] = req.val;
      promote_slot(hit);
    end else begin
      // Clamp capacity to 1 .. MAX_ENTRIES
      room = (capacity_reg == 0) ? 1 :
             (capacity_reg > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(capacity_reg);
      if (live_count >= room) begin
        // Drop the oldest live entry and reuse its slot
        for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
          if (slot_live[i] && (slot < 0 || slot_age[i] > slot_age[slot])) slot = i;
        end
        resp.evicted     = 1'b1;
        resp.evicted_key = slot_key[slot];
        slot_live[slot]  = 1'b0;
        live_count--;
      end else begin
        for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
          if (slot < 0 && !slot_live[i]) slot = i;
        end
      end
      for (i = 0; i < MAX_ENTRIES_DEF; i++) begin
        if (slot_live[i]) slot_age[i]++;
      end
      slot_key[slot]   = req.key;
      slot_value[slot] = req.val;
      slot_live[slot]  = 1'b1;
      slot_age[slot]   = 0;
      live_count++;
    end
    return resp;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
    error_count++;
    $display("cycle %0d: %s: expected %h, got %h", cycle_count, what, want, got);
  endtask

  // Driver: present the next queued item at the falling edge, hold it until taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = req_queue.pop_front();
          in_valid_i    <= 1'b1;
          operation_i   <= next_req.op;
          lookup_key_i  <= next_req.key;
          write_value_i <= next_req.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predict on every accepted item, check every accepted result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        returned_count <= returned_count + 1;
        if (resp_queue.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, read_value_o);
        end else begin
          due_resp = resp_queue.pop_front();
          if (found_o !== due_resp.found)
            report_mismatch("found", DATA_W'(due_resp.found), DATA_W'(found_o));
          if (read_value_o !== due_resp.read_value)
            report_mismatch("read_value", due_resp.read_value, read_value_o);
          if (evicted_o !== due_resp.evicted)
            report_mismatch("evicted", DATA_W'(due_resp.evicted), DATA_W'(evicted_o));
          if (evicted_key_o !== due_resp.evicted_key)
            report_mismatch("evicted_key", due_resp.evicted_key, evicted_key_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        accepted_count <= accepted_count + 1;
        resp_queue.push_back(
          cache_access(cache_req_t'{operation_i, lookup_key_i, write_value_i}));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic queue_req(input logic op, input logic [DATA_W-1:0] key,
                           input logic [DATA_W-1:0] val);
    req_queue.push_back(cache_req_t'{op, key, val});
  endtask

  // Hold until every queued item is taken and every result has come back
  task automatic await_idle();
    do begin
      @(posedge clk_i);
    end while (req_queue.size() != 0 || in_valid_i || accepted_count != returned_count);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    capacity_reg = cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly keys from a small pool so hits and evictions are frequent
  function automatic cache_req_t random_request(input int span);
    cache_req_t req;
    req.op  = 1'($urandom_range(1));
    req.key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(span - 1)] : $urandom;
    req.val = $urandom;
    return req;
  endfunction

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int send_pct,
                           input int stall_pct, input int count, input int span);
    int i;
    await_idle();
    write_capacity(cap);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    @(posedge clk_i);
    for (i = 0; i < count; i++) begin
      // Pause the sender halfway until the cache has drained
      if (i == count / 2) await_idle();
      req_queue.push_back(random_request(span));
    end
  endtask

  initial begin
    int k;
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'h7fff_ffff;
    for (k = 4; k < POOL_SIZE; k++) key_pool[k] = $urandom;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty miss, extreme keys and values, update, fill and evict
    queue_req(OP_GET, '0, $urandom);
    queue_req(OP_PUT, '0, 32'h7fff_ffff);
    queue_req(OP_PUT, '1, 32'h8000_0000);
    queue_req(OP_PUT, 32'h7fff_ffff, '1);
    queue_req(OP_PUT, 32'h8000_0000, '0);
    queue_req(OP_GET, '1, $urandom);
    queue_req(OP_GET, '0, '1);
    queue_req(OP_PUT, '0, 32'h1234_5678);
    queue_req(OP_GET, '0, '0);
    for (k = 1; k <= 12; k++) queue_req(OP_PUT, DATA_W'(k), DATA_W'(k * 10007));
    queue_req(OP_PUT, 32'd100, 32'd55);
    queue_req(OP_GET, 32'h7fff_ffff, '0);
    queue_req(OP_GET, 32'h8000_0000, '0);

    // Random phases over capacity settings, extremes and out-of-range values included
    run_phase(5'd0, 0, 0, 150, 6);
    run_phase(5'd31, 45, 0, 250, 40);
    run_phase(5'd1, 0, 45, 200, 4);
    run_phase(5'd16, 32, 32, 300, 24);
    run_phase(5'd17, 0, 0, 200, 30);
    run_phase(CAP_W'($urandom_range(2, 15)), 45, 0, 250, 20);
    run_phase(5'd8, 0, 45, 200, 12);
    run_phase(5'd3, 32, 32, 200, POOL_SIZE);

    await_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && resp_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> lru_key_value_cache_top.f
hdl/lrukv_pkg.sv
hdl/lrukv_ram.sv
hdl/lrukv_rank.sv
hdl/lru_key_value_cache_top.sv
tb/sv/tb_top.sv
